// ===== sv/ofr_pkg.sv =====
// Shared constants, register codes and controller/datapath handshake types for the framer.
package ofr_pkg;

    localparam int POS_W       = 40;
    localparam int BLOCK_W     = 7;
    localparam int STEP_W      = 16;
    localparam int INDEX_W     = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MAX_OUT     = 64;
    localparam int BLOCK_RESET = 64;
    localparam int STEP_RESET  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 2'd1;

    localparam logic ACT_PAD = 1'b1;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic accept;
        logic load_frame;
        logic issue;
        logic advance;
        logic marker;
    } ofr_cmd_t;

    typedef struct packed {
        logic finished;
        logic frame_due;
        logic end_mark;
        logic can_issue;
        logic idx_last;
        logic frame_final;
        logic blk_le_half;
        logic blk_lt_half;
        logic blk_lt_full;
    } ofr_status_t;

endpackage

// ===== sv/ofr_ifs.sv =====
// Valid/ready stream interfaces for input samples and output frame words.
interface ofr_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, action, sample_in, input ready);
    modport sink   (input valid, action, sample_in, output ready);
endinterface

interface ofr_out_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] frame_sample;
    logic [5:0]                    sample_index;
    logic                          frame_last;
    logic                          stream_done;

    modport source (output valid, frame_sample, sample_index, frame_last, stream_done,
                    input ready);
    modport sink   (input valid, frame_sample, sample_index, frame_last, stream_done,
                    output ready);
endinterface

// ===== sv/overlapping_audio_framer_core.sv =====
// Top level of the overlapping audio framer: controller plus datapath.
// The framer cuts a mono sample stream into frames of block_size samples, one frame every
// step_size samples, as if round(block_size/2) zeros preceded the stream; after the real
// samples, padding items (action = 1) feed zeros until the last frame, whose final word
// carries stream_done, after which items are taken and dropped. If the end shows up with
// no frame left, a lone word with stream_done and a zero sample marks it. Each output
// word is one frame sample with its index in the frame and a frame_last flag. An item that
// completes no frame passes through accept and frame check only; each frame it completes
// is read out word by word, because the MAX_BLOCK-entry sample ring has one registered read
// port feeding a single output register, so a word is not read from the ring while the
// previous read is in flight; an end marker adds the marker state. Output stalls hold the
// emission. A write to either configuration register restarts the
// stream at once from the new values and clears the ring through per-entry valid bits,
// so no clearing pass is needed after reset or reconfiguration; write registers only
// while the framer is idle.
module overlapping_audio_framer_core #(
    parameter int MAX_BLOCK   = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ofr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ofr_pkg::CFG_DATA_W-1:0] cfg_data,
    ofr_in_if.sink                         samples,
    ofr_out_if.source                      frames
);
    import ofr_pkg::*;

    ofr_cmd_t    cmd;
    ofr_status_t status;
    logic        in_ready;

    // sequencing: accept a word, check for completed frames, stream each one out
    ofr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign samples.ready = in_ready;

    // ring, positions and output register
    ofr_datapath #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .action       (samples.action),
        .sample_in    (samples.sample_in),
        .out_ready    (frames.ready),
        .out_valid    (frames.valid),
        .frame_sample (frames.frame_sample),
        .sample_index (frames.sample_index),
        .frame_last   (frames.frame_last),
        .stream_done  (frames.stream_done)
    );

endmodule

// ===== sv/ofr_datapath.sv =====
// Framer datapath: sample ring, stream positions, ring read pipe and output register.
module ofr_datapath #(
    parameter int MAX_BLOCK   = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ofr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ofr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  ofr_pkg::ofr_cmd_t                cmd,
    output ofr_pkg::ofr_status_t             status,
    input  logic                             action,
    input  logic signed [SAMPLE_BITS-1:0]    sample_in,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic signed [SAMPLE_BITS-1:0]    frame_sample,
    output logic [ofr_pkg::INDEX_W-1:0]      sample_index,
    output logic                             frame_last,
    output logic                             stream_done
);
    import ofr_pkg::*;

    localparam int AW      = $clog2(MAX_BLOCK);
    localparam int DW      = $clog2(MAX_BLOCK + 1);
    localparam int BW1     = BLOCK_W + 1;
    localparam int PW1     = POS_W + 1;
    localparam int RST_BLK = (BLOCK_RESET > MAX_BLOCK) ? MAX_BLOCK : BLOCK_RESET;
    localparam int RST_OFF = (RST_BLK + 1) / 2;
    localparam logic [BLOCK_W-1:0] MAX_BLK  = BLOCK_W'(MAX_BLOCK);
    localparam logic [AW-1:0]      LAST_PTR = AW'(MAX_BLOCK - 1);

    function automatic logic [BLOCK_W-1:0] eff_block(input logic [BLOCK_W-1:0] b);
        logic [BLOCK_W-1:0] r;
        if (b == '0)
        begin
            r = BLOCK_W'(1);
        end
        else if (b > MAX_BLK)
        begin
            r = MAX_BLK;
        end
        else
        begin
            r = b;
        end
        return r;
    endfunction

    function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] s);
        return (s == '0) ? STEP_W'(1) : s;
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + AW'(1);
    endfunction

    // configuration
    logic [BLOCK_W-1:0] block_reg;
    logic [STEP_W-1:0]  step_reg;

    // stream positions
    pos_t           vc_reg;
    logic [AW-1:0]  vc_ptr_reg;
    pos_t           limit_reg;
    pos_t           nfe_reg;
    pos_t           fp_reg;
    // start of the following frame, with a carry bit so the end test sees the full sum
    logic [PW1-1:0] fp_next_reg;
    logic           finished_reg;
    logic           pad_reg;
    logic           last_reg;

    // ring and read pipe
    logic [SAMPLE_BITS-1:0] ring_mem [MAX_BLOCK];
    logic [MAX_BLOCK-1:0]   valid_reg;
    logic [AW-1:0]          rd_ptr_reg;
    logic [AW-1:0]          idx_reg;
    logic                   rd_inflight_reg;
    logic                   rd_vld_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [AW-1:0]          rd_idx_reg;
    logic                   rd_last_reg;
    logic                   rd_done_reg;

    // output register
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] frame_sample_reg;
    logic [INDEX_W-1:0]            sample_index_reg;
    logic                          frame_last_reg;
    logic                          stream_done_reg;

    logic               wr_block;
    logic               wr_step;
    logic               restart;
    logic [BLOCK_W-1:0] new_block;
    logic [STEP_W-1:0]  new_step;
    logic [BLOCK_W-1:0] nb_eff;
    logic [STEP_W-1:0]  ns_eff;
    logic [BLOCK_W-1:0] n_off;
    logic [BLOCK_W-1:0] blk_eff;
    logic [STEP_W-1:0]  stp_eff;
    logic               pad_now;
    logic [DW-1:0]      back_len;
    logic [DW-1:0]      ptr_ext;
    logic [AW-1:0]      start_slot;
    logic               out_free;
    logic               idx_last;

    always_comb
    begin
        wr_block  = cfg_we && (cfg_index == REG_BLOCK_SIZE);
        wr_step   = cfg_we && (cfg_index == REG_STEP_SIZE);
        restart   = wr_block || wr_step;
        new_block = wr_block ? cfg_data[BLOCK_W-1:0] : block_reg;
        new_step  = wr_step ? cfg_data : step_reg;
        nb_eff    = eff_block(new_block);
        ns_eff    = eff_step(new_step);
        n_off     = BLOCK_W'(({1'b0, nb_eff} + BW1'(1)) >> 1);
        blk_eff   = eff_block(block_reg);
        stp_eff   = eff_step(step_reg);
    end

    always_comb
    begin
        pad_now  = (action == ACT_PAD) || (vc_reg != limit_reg);
        // distance back from the write head to the frame start never exceeds the ring
        back_len = vc_reg[DW-1:0] - nfe_reg[DW-1:0] + blk_eff[DW-1:0];
        ptr_ext  = DW'(vc_ptr_reg);
        if (ptr_ext >= back_len)
        begin
            start_slot = AW'(ptr_ext - back_len);
        end
        else
        begin
            start_slot = AW'(ptr_ext + (DW'(MAX_BLOCK) - back_len));
        end
        out_free = !out_valid_reg || out_ready;
        idx_last = (DW'(idx_reg) == (blk_eff[DW-1:0] - DW'(1)));
    end

    always_comb
    begin
        status.finished    = finished_reg;
        status.frame_due   = (nfe_reg <= vc_reg) && (fp_reg < limit_reg);
        status.end_mark    = pad_reg && !(fp_reg < limit_reg);
        status.can_issue   = out_free && !rd_inflight_reg;
        status.idx_last    = idx_last;
        status.frame_final = last_reg;
        status.blk_le_half = blk_eff <= BLOCK_W'(MAX_OUT / 2);
        status.blk_lt_half = blk_eff < BLOCK_W'(MAX_OUT / 2);
        status.blk_lt_full = blk_eff < BLOCK_W'(MAX_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_reg    <= BLOCK_W'(BLOCK_RESET);
            step_reg     <= STEP_W'(STEP_RESET);
            vc_reg       <= POS_W'(RST_OFF);
            vc_ptr_reg   <= AW'(RST_OFF);
            limit_reg    <= POS_W'(RST_OFF);
            nfe_reg      <= POS_W'(RST_BLK);
            fp_reg       <= '0;
            fp_next_reg  <= PW1'(STEP_RESET);
            finished_reg <= 1'b0;
            pad_reg      <= 1'b0;
            last_reg     <= 1'b0;
        end
        else if (restart)
        begin
            block_reg    <= new_block;
            step_reg     <= new_step;
            vc_reg       <= POS_W'(n_off);
            vc_ptr_reg   <= AW'(n_off);
            limit_reg    <= POS_W'(n_off);
            nfe_reg      <= POS_W'(nb_eff);
            fp_reg       <= '0;
            fp_next_reg  <= PW1'(ns_eff);
            finished_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                pad_reg    <= pad_now;
                vc_reg     <= vc_reg + POS_W'(1);
                vc_ptr_reg <= ptr_inc(vc_ptr_reg);
                if (!pad_now)
                begin
                    limit_reg <= limit_reg + POS_W'(1);
                end
            end
            if (cmd.load_frame)
            begin
                last_reg <= pad_reg && (fp_next_reg >= {1'b0, limit_reg});
            end
            if (cmd.advance)
            begin
                fp_reg      <= fp_next_reg[POS_W-1:0];
                fp_next_reg <= {1'b0, fp_next_reg[POS_W-1:0]} + PW1'(stp_eff);
                nfe_reg     <= fp_next_reg[POS_W-1:0] + POS_W'(blk_eff);
                if (last_reg)
                begin
                    finished_reg <= 1'b1;
                end
            end
            if (cmd.marker)
            begin
                finished_reg <= 1'b1;
            end
        end
    end

    // ring storage: one write port at accept, one registered read port at issue
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ring_mem[vc_ptr_reg] <= pad_now ? '0 : sample_in;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (restart)
        begin
            valid_reg <= '0;
        end
        else if (cmd.accept)
        begin
            valid_reg[vc_ptr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_inflight_reg <= 1'b0;
            rd_ptr_reg      <= '0;
            idx_reg         <= '0;
        end
        else
        begin
            rd_inflight_reg <= cmd.issue;
            if (cmd.load_frame)
            begin
                rd_ptr_reg <= start_slot;
                idx_reg    <= '0;
            end
            else if (cmd.issue)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
                idx_reg    <= idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_vld_reg  <= valid_reg[rd_ptr_reg];
            rd_idx_reg  <= idx_reg;
            rd_last_reg <= idx_last;
            rd_done_reg <= idx_last && last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rd_inflight_reg || cmd.marker)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_inflight_reg)
        begin
            frame_sample_reg <= rd_vld_reg ? rd_data_reg : '0;
            sample_index_reg <= INDEX_W'(rd_idx_reg);
            frame_last_reg   <= rd_last_reg;
            stream_done_reg  <= rd_done_reg;
        end
        else if (cmd.marker)
        begin
            frame_sample_reg <= '0;
            sample_index_reg <= '0;
            frame_last_reg   <= 1'b0;
            stream_done_reg  <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_sample = frame_sample_reg;
    assign sample_index = sample_index_reg;
    assign frame_last   = frame_last_reg;
    assign stream_done  = stream_done_reg;

    a_land_free: assert property (@(posedge clk) disable iff (!rst_n)
        rd_inflight_reg |-> !out_valid_reg)
        else $error("ring read landed on an occupied output register");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg && !restart |=> finished_reg)
        else $error("finished flag dropped without a restart");

    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && stream_done_reg |->
            frame_last_reg || (sample_index_reg == '0 && frame_sample_reg == '0))
        else $error("stream_done on a word that is neither a frame end nor the marker");

endmodule

// ===== sv/ofr_ctrl.sv =====
// Framer controller: sequences accept, frame check, sample emission and frame advance.
module ofr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ofr_pkg::ofr_status_t status,
    output ofr_pkg::ofr_cmd_t    cmd
);
    import ofr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_EMIT  = 5'b00100,
        S_ADV   = 5'b01000,
        S_MARK  = 5'b10000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] frame_cnt_reg;
    logic [1:0] frame_cnt_next;
    logic       frame_room;
    logic       mark_room;

    always_comb
    begin
        // at most two frames per item, and never more than MAX_OUT words
        frame_room = (frame_cnt_reg == 2'd0) ||
                     ((frame_cnt_reg == 2'd1) && status.blk_le_half);
        mark_room  = (frame_cnt_reg == 2'd0) ||
                     ((frame_cnt_reg == 2'd1) && status.blk_lt_full) ||
                     ((frame_cnt_reg == 2'd2) && status.blk_lt_half);
    end

    always_comb
    begin
        state_next     = state_reg;
        frame_cnt_next = frame_cnt_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                // after the stream ends, take items and drop them
                if (in_valid && !status.finished)
                begin
                    cmd.accept     = 1'b1;
                    frame_cnt_next = 2'd0;
                    state_next     = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.frame_due && frame_room)
                begin
                    cmd.load_frame = 1'b1;
                    state_next     = S_EMIT;
                end
                else if (status.end_mark && mark_room)
                begin
                    state_next = S_MARK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (status.can_issue)
                begin
                    cmd.issue = 1'b1;
                    if (status.idx_last)
                    begin
                        state_next = S_ADV;
                    end
                end
            end
            S_ADV:
            begin
                cmd.advance    = 1'b1;
                frame_cnt_next = frame_cnt_reg + 2'd1;
                state_next     = status.frame_final ? S_IDLE : S_CHECK;
            end
            S_MARK:
            begin
                if (status.can_issue)
                begin
                    cmd.marker = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            frame_cnt_reg <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_cnt_reg <= frame_cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_cnt_reg != 2'd3)
        else $error("more than two frames counted for one item");

    a_adv_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADV |-> $past(state_reg == S_EMIT))
        else $error("frame advance without emission");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == S_CHECK)
        else $error("accepted item not followed by a frame check");

endmodule

// ===== tb/tb_overlapping_audio_framer_core.sv =====
// Self-checking testbench for the overlapping audio framer core.
module tb_overlapping_audio_framer_core;
    import ofr_pkg::*;

    localparam int SMP_W         = 24;
    localparam int RING_DEPTH    = 64;
    localparam int RANDOM_ITEMS  = 380;
    // An item that completes no frame keeps the core busy through accept and frame
    // check, an end marker through its own state as well; wait longer before a write.
    localparam int SETTLE_CYCLES = 8;
    localparam longint TIMEOUT   = 64'd10 * 64'd1_000_000;

    // Indexes that map to no register; a write there must leave the stream alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam logic ACT_SAMPLE = 1'b0;

    typedef struct packed {
        logic [SMP_W-1:0]   smp;
        logic [INDEX_W-1:0] idx;
        logic               last;
        logic               done;
    } frame_word_t;

    // Frame predictor plus the queue of frame words still owed by the core.
    class frame_scoreboard;
        logic [BLOCK_W-1:0] block_reg;
        logic [STEP_W-1:0]  step_reg;
        logic [SMP_W-1:0]   ring [RING_DEPTH];
        pos_t               next_pos;
        pos_t               frame_end;
        pos_t               frame_start;
        pos_t               real_count;
        bit                 finished;
        frame_word_t        pending [$];
        int                 errors;

        function new();
            block_reg = BLOCK_W'(BLOCK_RESET);
            step_reg  = STEP_W'(STEP_RESET);
            errors    = 0;
            restart();
        endfunction

        function int unsigned block_len();
            if (block_reg == 0) return 1;
            if (block_reg > RING_DEPTH) return RING_DEPTH;
            return block_reg;
        endfunction

        function int unsigned hop();
            return (step_reg == 0) ? 1 : step_reg;
        endfunction

        function int unsigned lead_zeros();
            return (block_len() + 1) / 2;
        endfunction

        function void restart();
            foreach (ring[i]) ring[i] = '0;
            next_pos    = pos_t'(lead_zeros());
            frame_end   = pos_t'(block_len());
            frame_start = '0;
            real_count  = '0;
            finished    = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BLOCK_SIZE:
                begin
                    block_reg = data[BLOCK_W-1:0];
                    restart();
                end
                REG_STEP_SIZE:
                begin
                    step_reg = data[STEP_W-1:0];
                    restart();
                end
                default: ;
            endcase
        endfunction

        // Take one accepted input word; queue the frame words it completes.
        // Return 1 when the word is dropped because the stream has ended.
        function bit note_word(logic act, logic [SMP_W-1:0] smp);
            int unsigned blk;
            int unsigned stp;
            pos_t        v;
            pos_t        limit;
            pos_t        start;
            pos_t        slot;
            logic [POS_W:0] reach;
            bit          pad;
            bit          last;
            int          n;
            int          frames;
            frame_word_t w;
            if (finished) return 1'b1;
            blk = block_len();
            stp = hop();
            v   = next_pos;
            // Once padding has begun, real samples count as padding too.
            pad = (act == ACT_PAD) || (v != real_count + pos_t'(lead_zeros()));
            ring[v[5:0]] = pad ? '0 : smp;
            if (!pad) real_count = real_count + 1'b1;
            next_pos = v + 1'b1;
            limit    = real_count + pos_t'(lead_zeros());
            n        = 0;
            frames   = 0;
            while (frames < 2 && frame_end <= next_pos && frame_start < limit
                   && n + blk <= MAX_OUT)
            begin
                start = frame_end - pos_t'(blk);
                reach = {1'b0, frame_start} + (POS_W+1)'(stp);
                last  = pad && (reach >= {1'b0, limit});
                for (int i = 0; i < blk; i++)
                begin
                    slot   = start + pos_t'(i);
                    w.smp  = ring[slot[5:0]];
                    w.idx  = INDEX_W'(i);
                    w.last = (i == blk - 1);
                    w.done = w.last && last;
                    pending.push_back(w);
                    n++;
                end
                frames++;
                frame_start = frame_start + pos_t'(stp);
                frame_end   = frame_start + pos_t'(blk);
                if (last)
                begin
                    finished = 1'b1;
                    return 1'b0;
                end
            end
            // End seen with no frame left: a lone done marker.
            if (pad && frame_start >= limit && n < MAX_OUT)
            begin
                finished = 1'b1;
                w = '{smp: '0, idx: '0, last: 1'b0, done: 1'b1};
                pending.push_back(w);
            end
            return 1'b0;
        endfunction

        function void compare_field(string field, logic [SMP_W-1:0] want,
                                    logic [SMP_W-1:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            end
        endfunction

        function void check_word(frame_word_t got);
            frame_word_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected frame word, expected none, got %h/%0d/%b/%b",
                         $time, got.smp, got.idx, got.last, got.done);
                return;
            end
            want = pending.pop_front();
            compare_field("frame_sample", want.smp, got.smp);
            compare_field("sample_index", SMP_W'(want.idx), SMP_W'(got.idx));
            compare_field("frame_last", SMP_W'(want.last), SMP_W'(got.last));
            compare_field("stream_done", SMP_W'(want.done), SMP_W'(got.done));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ofr_in_if  #(.SAMPLE_BITS(SMP_W)) samples_if ();
    ofr_out_if #(.SAMPLE_BITS(SMP_W)) frames_if ();

    overlapping_audio_framer_core #(
        .MAX_BLOCK   (RING_DEPTH),
        .SAMPLE_BITS (SMP_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_if),
        .frames    (frames_if)
    );

    frame_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int items_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the core hangs or loses a word.
    initial
    begin
        #(TIMEOUT);
        $display("tb: failure");
        $finish;
    end

    // Throttle the frame side: drop ready at random, once per falling edge.
    always @(negedge clk)
    begin
        frames_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every frame word on the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && frames_if.valid && frames_if.ready)
        begin
            sb.check_word('{smp:  frames_if.frame_sample,
                            idx:  frames_if.sample_index,
                            last: frames_if.frame_last,
                            done: frames_if.stream_done});
        end
    end

    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    // Offer one input word, idling at random first, and hold it until taken.
    // Leave valid high afterwards so back-to-back words need no toggle.
    task automatic send_item(input logic act, input logic [SMP_W-1:0] smp);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            samples_if.valid <= 1'b0;
            @(negedge clk);
        end
        samples_if.valid     <= 1'b1;
        samples_if.action    <= act;
        samples_if.sample_in <= smp;
        do @(posedge clk); while (!samples_if.ready);
        if (!sb.note_word(act, smp)) items_taken++;
    endtask

    // Stop offering input and wait until every owed frame word is out.
    task automatic drain_frames();
        @(negedge clk);
        samples_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Drain, then let the core finish any item that produced no word.
    task automatic settle();
        drain_frames();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_register(idx, data);
        @(posedge clk);
    endtask

    // Write both registers in random order, optionally after a stray write to
    // an unused index, then drop the write enable.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] blk_word,
                                  input logic [CFG_DATA_W-1:0] stp_word,
                                  input bit stray);
        if (stray)
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      CFG_DATA_W'($urandom));
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_BLOCK_SIZE, blk_word);
            write_reg(REG_STEP_SIZE, stp_word);
        end
        else
        begin
            write_reg(REG_STEP_SIZE, stp_word);
            write_reg(REG_BLOCK_SIZE, blk_word);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Feed padding until the stream ends; after the first tick, mix in real
    // samples, which the core must treat as padding.
    task automatic pad_until_done(input int noise_pct);
        send_item(ACT_PAD, pick_sample());
        while (!sb.finished)
            send_item(($urandom_range(0, 99) < noise_pct) ? ACT_SAMPLE : ACT_PAD,
                      pick_sample());
    endtask

    initial
    begin
        logic [BLOCK_W-1:0] blk7;
        logic [STEP_W-1:0]  stp;
        int                 blk_eff;
        int                 n_real;
        int                 pause_at;
        int                 directed_count;
        int                 progress;
        bit                 first;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        samples_if.valid     = 1'b0;
        samples_if.action    = ACT_SAMPLE;
        samples_if.sample_in = '0;
        frames_if.ready      = 1'b0;
        send_idle_pct        = 37;
        recv_idle_pct        = 64;
        items_taken          = 0;
        first                = 1'b1;
        sb                   = new();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Block of one: the first sample completes two frames; the first pad
        // tick then finds no frame due and yields the lone done marker.
        apply_settings(16'd1, 16'd1, 1'b1);
        send_item(ACT_SAMPLE, 24'h7FFFFF);
        send_item(ACT_SAMPLE, 24'h800000);
        pad_until_done(0);
        // Words after the end must be dropped.
        send_item(ACT_SAMPLE, 24'h123456);
        send_item(ACT_PAD, 24'hFFFFFF);
        settle();

        // Zero block and zero step act as one; junk above the block field.
        apply_settings(16'hFF80, 16'd0, 1'b0);
        send_item(ACT_SAMPLE, 24'hFFFFFF);
        send_item(ACT_SAMPLE, 24'h000000);
        pad_until_done(0);
        settle();

        // Last frame goes out on a real sample, so the end shows up as a marker.
        apply_settings(16'd2, 16'd4, 1'b0);
        send_item(ACT_SAMPLE, 24'h000001);
        send_item(ACT_SAMPLE, 24'h7FFFFF);
        pad_until_done(0);
        settle();

        // Real samples after padding has begun.
        apply_settings(16'd3, 16'd2, 1'b0);
        repeat (4) send_item(ACT_SAMPLE, pick_sample());
        pad_until_done(50);
        settle();

        directed_count = items_taken;

        // Random streams: new settings, real samples, then padding to the end.
        while (items_taken - directed_count < RANDOM_ITEMS)
        begin
            progress = items_taken - directed_count;
            if (progress < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 37;
                recv_idle_pct = 64;
            end
            else if (progress < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 37;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case ($urandom_range(0, 11))
                0:       blk7 = '0;
                1:       blk7 = BLOCK_W'($urandom_range(65, 127));
                2:       blk7 = 7'd64;
                3:       blk7 = 7'd1;
                4, 5:    blk7 = BLOCK_W'($urandom_range(17, 63));
                default: blk7 = BLOCK_W'($urandom_range(2, 16));
            endcase
            blk_eff = (blk7 == 0) ? 1 : ((blk7 > RING_DEPTH) ? RING_DEPTH : blk7);
            case ($urandom_range(0, 9))
                0:       stp = '0;
                1:       stp = 16'hFFFF;
                2:       stp = STEP_W'($urandom_range(1, 65535));
                3:       stp = 16'd1;
                default: stp = STEP_W'($urandom_range(1, 2 * blk_eff + 3));
            endcase
            apply_settings({9'($urandom_range(0, 511)), blk7}, stp,
                           $urandom_range(0, 7) == 0);

            case ($urandom_range(0, 9))
                0:       n_real = 0;
                1:       n_real = $urandom_range(65, 160);
                default: n_real = $urandom_range(1, 2 * blk_eff + 6);
            endcase
            // Hold the input side now and then until the frame side is empty.
            pause_at = (first || $urandom_range(0, 3) == 0) ? $urandom_range(0, n_real) : -1;
            first    = 1'b0;

            for (int k = 0; k < n_real; k++)
            begin
                if (k == pause_at) drain_frames();
                send_item(ACT_SAMPLE, pick_sample());
            end
            if (pause_at == n_real) drain_frames();

            // Mostly finish the stream; sometimes abandon it mid-way and let
            // the next register write restart it.
            if ($urandom_range(0, 9) != 0)
            begin
                pad_until_done(15);
                repeat ($urandom_range(0, 2))
                    send_item($urandom_range(0, 1) ? ACT_PAD : ACT_SAMPLE, pick_sample());
            end
            settle();
        end

        settle();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ofr_pkg.sv
sv/ofr_ifs.sv
sv/ofr_datapath.sv
sv/ofr_ctrl.sv
sv/overlapping_audio_framer_core.sv
tb/tb_overlapping_audio_framer_core.sv
